### rtl/core/lspd_pkg.sv
// Shared types, constants and arithmetic helpers of the scan packet decoder.
package lspd_pkg;

    // Field widths
    localparam int unsigned LsnW    = 7;   // sample count, 1..MAX_SAMPLES
    localparam int unsigned SampW   = 6;   // sample index within a frame
    localparam int unsigned RawW    = 16;  // raw little-endian word
    localparam int unsigned A10W    = 13;  // angle in tenths of a degree before wrap
    localparam int unsigned DiffW   = 14;  // signed span between end and start angle
    localparam int unsigned ProdW   = 21;  // signed span times sample index
    localparam int unsigned MagW    = 19;  // magnitude fed to the serial divider
    localparam int unsigned RemW    = 6;   // divider remainder
    localparam int unsigned DivCntW = 5;   // divider step counter
    localparam int unsigned ModW    = 12;  // reduced angle plus rounding term
    localparam int unsigned ScaleW  = 28;  // product of the divide-by-ten multiply

    // Header and frame layout
    localparam logic [7:0]  Hdr0     = 8'hAA;
    localparam logic [7:0]  Hdr1     = 8'h55;
    localparam logic [15:0] HdrWord  = 16'h55AA;
    localparam logic [7:0]  PosBody  = 8'd2;
    localparam logic [7:0]  PosLsn   = 8'd3;
    localparam logic [7:0]  PosStart = 8'd5;
    localparam logic [7:0]  PosEnd   = 8'd7;
    localparam logic [7:0]  PosChk   = 8'd9;
    localparam logic [7:0]  PosSamp  = 8'd11;
    localparam logic [8:0]  HeadLen  = 9'd10;

    // Angle arithmetic
    localparam logic [11:0] Turn10  = 12'd3600;
    localparam logic [8:0]  Turn    = 9'd360;
    localparam logic [11:0] Round10 = 12'd5;
    localparam logic [15:0] Recip10 = 16'd52429;  // 2^19 / 10, rounded up
    localparam int unsigned Recip10Shift = 19;

    // Input item
    typedef struct packed {
        logic [7:0] rx_byte;
    } t_in;

    // Result item
    typedef struct packed {
        logic [8:0]       bearing_deg;
        logic [13:0]      range_mm;
        logic             quality;
        logic             present;
        logic [SampW-1:0] sample_index;
        logic             last;
    } t_res;

    // Descriptor of an accepted frame, handed from parser to emitter
    typedef struct packed {
        logic [LsnW-1:0] lsn;
        logic [RawW-1:0] start_raw;
        logic [RawW-1:0] end_raw;
        logic            bank;
    } t_frame;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HDR1,
        PH_BODY
    } t_phase;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_ADD,
        BK_MOD,
        BK_SCALE,
        BK_OUT
    } t_bstate;

    // ((raw >> 1) * 10) / 64
    function automatic logic [A10W-1:0] tenths(input logic [RawW-1:0] raw);
        logic [14:0] r;
        logic [18:0] t;
        r = raw[15:1];
        t = 19'({r, 3'b000}) + 19'({r, 1'b0});
        return t[18:6];
    endfunction

    // value mod 3600 for a 16-bit value, five compare/subtract steps
    function automatic logic [11:0] mod3600(input logic [15:0] v);
        logic [16:0] acc;
        logic [16:0] c;
        acc = {1'b0, v};
        for (int k = 4; k >= 0; k--) begin
            c = 17'(Turn10) << k;
            if (acc >= c) begin
                acc = acc - c;
            end
        end
        return acc[11:0];
    endfunction

endpackage

### rtl/core/lspd_stream_if.sv
// Valid/ready stream channel carrying one payload struct.
interface lspd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/lspd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lspd_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/lspd_front.sv
// Byte parser: header hunt, frame fields, checksum and sample writes.
module lspd_front #(
    parameter int unsigned MAX_SAMPLES = 40,
    parameter int unsigned AW          = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    lspd_stream_if.sink            i_byte,
    input  logic                   i_full,
    output logic                   o_push,
    output lspd_pkg::t_frame       o_frame,
    output logic                   o_we,
    output logic [AW-1:0]          o_waddr,
    output logic [15:0]            o_wdata
);
    lspd_pkg::t_phase r_phase, n_phase;
    logic [7:0]                r_pos, n_pos;
    logic [lspd_pkg::LsnW-1:0] r_lsn, n_lsn;
    logic [15:0]               r_start, n_start;
    logic [15:0]               r_end, n_end;
    logic [15:0]               r_xor, n_xor;
    logic [7:0]                r_low, n_low;
    logic                      r_bank, n_bank;

    logic        w_acc;
    logic [7:0]  w_b;
    logic [15:0] w_word;
    logic [15:0] w_xor;
    logic        w_lsn_bad;
    logic        w_frame_end;
    logic [7:0]  w_idx;

    // Stall only when both sample banks hold frames awaiting emission
    assign i_byte.ready = !i_full;
    assign w_acc        = i_byte.valid && !i_full;
    assign w_b          = i_byte.data.rx_byte;

    assign w_word      = {w_b, r_low};
    assign w_xor       = r_xor ^ w_word;
    assign w_lsn_bad   = (w_b == 8'd0) || (w_b > 8'(MAX_SAMPLES));
    assign w_frame_end = (r_pos >= lspd_pkg::PosChk) &&
                         (9'(r_pos) + 9'd1 >= lspd_pkg::HeadLen + 9'({r_lsn, 1'b0}));
    assign w_idx       = (r_pos - lspd_pkg::PosSamp) >> 1;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            lspd_pkg::PH_HUNT: begin
                if (w_acc && w_b == lspd_pkg::Hdr0) begin
                    n_phase = lspd_pkg::PH_HDR1;
                end
            end
            lspd_pkg::PH_HDR1: begin
                if (w_acc) begin
                    if (w_b == lspd_pkg::Hdr1) begin
                        n_phase = lspd_pkg::PH_BODY;
                    end else if (w_b != lspd_pkg::Hdr0) begin
                        n_phase = lspd_pkg::PH_HUNT;
                    end
                end
            end
            lspd_pkg::PH_BODY: begin
                if (w_acc && ((r_pos == lspd_pkg::PosLsn && w_lsn_bad) || w_frame_end)) begin
                    n_phase = lspd_pkg::PH_HUNT;
                end
            end
            default: n_phase = lspd_pkg::PH_HUNT;
        endcase
    end

    // Field capture, checksum, sample writes and frame hand-off
    always_comb begin
        n_pos   = r_pos;
        n_lsn   = r_lsn;
        n_start = r_start;
        n_end   = r_end;
        n_xor   = r_xor;
        n_low   = r_low;
        n_bank  = r_bank;
        o_we    = 1'b0;
        o_push  = 1'b0;
        if (w_acc && r_phase == lspd_pkg::PH_HDR1 && w_b == lspd_pkg::Hdr1) begin
            n_pos = lspd_pkg::PosBody;
            n_xor = lspd_pkg::HdrWord;
        end
        if (w_acc && r_phase == lspd_pkg::PH_BODY) begin
            if (r_pos[0]) begin
                n_xor = w_xor;
            end else begin
                n_low = w_b;
            end
            n_pos = r_pos + 8'd1;
            if (r_pos == lspd_pkg::PosLsn) begin
                if (w_lsn_bad) begin
                    n_pos = '0;
                end else begin
                    n_lsn = w_b[lspd_pkg::LsnW-1:0];
                end
            end
            if (r_pos == lspd_pkg::PosStart) begin
                n_start = w_word;
            end
            if (r_pos == lspd_pkg::PosEnd) begin
                n_end = w_word;
            end
            if (r_pos >= lspd_pkg::PosSamp && r_pos[0]) begin
                o_we = 1'b1;
            end
            if (w_frame_end) begin
                n_pos = '0;
                if (w_xor == 16'd0) begin
                    o_push = 1'b1;
                    n_bank = !r_bank;
                end
            end
        end
    end

    assign o_wdata = w_word;
    assign o_waddr = AW'(w_idx) + (r_bank ? AW'(MAX_SAMPLES) : AW'(0));
    assign o_frame = '{lsn: r_lsn, start_raw: r_start, end_raw: r_end, bank: r_bank};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lspd_pkg::PH_HUNT;
            r_pos   <= '0;
            r_lsn   <= '0;
            r_start <= '0;
            r_end   <= '0;
            r_xor   <= '0;
            r_low   <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_lsn   <= n_lsn;
            r_start <= n_start;
            r_end   <= n_end;
            r_xor   <= n_xor;
            r_low   <= n_low;
            r_bank  <= n_bank;
        end
    end
endmodule

### rtl/core/lspd_fifo.sv
// Two-entry queue of accepted frame descriptors, one per sample bank.
module lspd_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lspd_pkg::t_frame i_frame,
    input  logic             i_pop,
    output lspd_pkg::t_frame o_head,
    output logic             o_full,
    output logic             o_empty
);
    lspd_pkg::t_frame r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_frame;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
endmodule

### rtl/core/lspd_back.sv
// Sample emitter: angle interpolation with a serial divider, result register.
module lspd_back #(
    parameter int unsigned MAX_SAMPLES = 40,
    parameter int unsigned AW          = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  lspd_pkg::t_frame i_frame,
    output logic             o_pop,
    output logic             o_re,
    output logic [AW-1:0]    o_raddr,
    input  logic [15:0]      i_rdata,
    lspd_stream_if.source    o_res
);
    lspd_pkg::t_bstate r_st, n_st;

    logic [lspd_pkg::SampW-1:0]   r_s;
    logic [lspd_pkg::A10W-1:0]    r_a0;
    logic signed [lspd_pkg::DiffW-1:0] r_diff;
    logic [lspd_pkg::MagW-1:0]    r_mag;
    logic [lspd_pkg::MagW-1:0]    r_quo;
    logic [lspd_pkg::RemW-1:0]    r_rem;
    logic                         r_neg;
    logic [lspd_pkg::DivCntW-1:0] r_cnt;
    logic [15:0]                  r_ux;
    logic [lspd_pkg::ModW-1:0]    r_v;
    logic [lspd_pkg::ScaleW-1:0]  r_scaled;
    logic                         r_ov;
    lspd_pkg::t_res               r_od;

    logic                              w_out_free;
    logic                              w_load;
    logic                              w_last;
    logic [lspd_pkg::RemW-1:0]         w_den;
    logic signed [lspd_pkg::DiffW-1:0] w_diff;
    logic signed [lspd_pkg::ProdW-1:0] w_prod;
    logic [lspd_pkg::RemW:0]           w_trial;
    logic                              w_qbit;
    logic signed [lspd_pkg::ProdW-1:0] w_q;
    logic signed [lspd_pkg::ProdW-1:0] w_x;
    logic [8:0]                        w_angle;
    logic [13:0]                       w_dist;

    assign w_out_free = !r_ov || o_res.ready;
    assign w_last     = (r_s == lspd_pkg::SampW'(i_frame.lsn - 1'b1));
    assign w_den      = lspd_pkg::RemW'(i_frame.lsn - 1'b1);

    // Span between end and start angle, wrapped once by a full turn
    always_comb begin
        w_diff = $signed({1'b0, lspd_pkg::tenths(i_frame.end_raw)}) -
                 $signed({1'b0, lspd_pkg::tenths(i_frame.start_raw)});
        if (w_diff < 0) begin
            w_diff = w_diff + $signed(lspd_pkg::DiffW'(lspd_pkg::Turn10));
        end
    end

    assign w_prod  = lspd_pkg::ProdW'(r_diff) *
                     lspd_pkg::ProdW'($signed({1'b0, r_s}));
    assign w_trial = {r_rem, r_mag[lspd_pkg::MagW-1]};
    assign w_qbit  = (w_trial >= {1'b0, w_den});
    assign w_q     = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});
    assign w_x     = $signed({8'b0, r_a0}) + w_q;
    assign w_angle = (r_scaled[lspd_pkg::ScaleW-1:lspd_pkg::Recip10Shift] == lspd_pkg::Turn) ?
                     9'd0 : r_scaled[lspd_pkg::ScaleW-1:lspd_pkg::Recip10Shift];
    assign w_dist  = i_rdata[15:2];

    // Next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            lspd_pkg::BK_IDLE:  if (!i_empty) n_st = lspd_pkg::BK_MUL;
            lspd_pkg::BK_MUL:   n_st = lspd_pkg::BK_DIV;
            lspd_pkg::BK_DIV:   if (r_cnt == lspd_pkg::DivCntW'(1)) n_st = lspd_pkg::BK_ADD;
            lspd_pkg::BK_ADD:   n_st = lspd_pkg::BK_MOD;
            lspd_pkg::BK_MOD:   n_st = lspd_pkg::BK_SCALE;
            lspd_pkg::BK_SCALE: n_st = lspd_pkg::BK_OUT;
            lspd_pkg::BK_OUT: begin
                if (w_out_free) begin
                    n_st = w_last ? lspd_pkg::BK_IDLE : lspd_pkg::BK_MUL;
                end
            end
            default: n_st = lspd_pkg::BK_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_re   = 1'b0;
        w_load = 1'b0;
        o_pop  = 1'b0;
        unique case (r_st)
            lspd_pkg::BK_MUL: o_re = 1'b1;
            lspd_pkg::BK_OUT: begin
                w_load = w_out_free;
                o_pop  = w_out_free && w_last;
            end
            default: ;
        endcase
    end

    assign o_raddr = AW'(r_s) + (i_frame.bank ? AW'(MAX_SAMPLES) : AW'(0));

    // Angle datapath
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            lspd_pkg::BK_IDLE: begin
                r_a0   <= lspd_pkg::tenths(i_frame.start_raw);
                r_diff <= w_diff;
            end
            lspd_pkg::BK_MUL: begin
                r_neg <= w_prod[lspd_pkg::ProdW-1];
                r_mag <= w_prod[lspd_pkg::ProdW-1] ? lspd_pkg::MagW'(-w_prod) :
                                                     lspd_pkg::MagW'(w_prod);
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= lspd_pkg::DivCntW'(lspd_pkg::MagW);
            end
            lspd_pkg::BK_DIV: begin
                r_rem <= w_qbit ? lspd_pkg::RemW'(w_trial - {1'b0, w_den}) :
                                  lspd_pkg::RemW'(w_trial);
                r_quo <= {r_quo[lspd_pkg::MagW-2:0], w_qbit};
                r_mag <= r_mag << 1;
                r_cnt <= r_cnt - 1'b1;
            end
            lspd_pkg::BK_ADD: begin
                // single-sample frame takes the start angle as is
                r_ux <= (i_frame.lsn == lspd_pkg::LsnW'(1)) ? 16'(r_a0) : w_x[15:0];
            end
            lspd_pkg::BK_MOD: begin
                r_v <= lspd_pkg::mod3600(r_ux) + lspd_pkg::Round10;
            end
            lspd_pkg::BK_SCALE: begin
                r_scaled <= lspd_pkg::ScaleW'(r_v) * lspd_pkg::ScaleW'(lspd_pkg::Recip10);
            end
            default: ;
        endcase
    end

    // Sample counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
        end else if (r_st == lspd_pkg::BK_IDLE) begin
            r_s <= '0;
        end else if (w_load) begin
            r_s <= r_s + 1'b1;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_od <= '{bearing_deg:  w_angle,
                      range_mm:     w_dist,
                      quality:      !i_rdata[0],
                      present:      (w_dist != 14'd0),
                      sample_index: r_s,
                      last:         w_last};
        end
    end

    assign o_res.valid = r_ov;
    assign o_res.data  = r_od;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= lspd_pkg::BK_IDLE;
        end else begin
            r_st <= n_st;
        end
    end
endmodule

### rtl/core/lidar_scan_packet_decoder.sv
// Top level: parser, frame queue, two-bank sample RAM and sample emitter.
//
// Bytes of a scan packet enter on i_byte, one per transaction, and are taken at one per
// cycle; the parser only stalls while two checked frames are still waiting to be emitted,
// since each frame owns one of two sample banks until its last result has been loaded.
// Each frame that passes the XOR check yields one result per sample on o_res. Each result
// needs emitter work: one multiply, a 19-step one-bit-per-cycle divider, then add,
// reduction modulo 3600 and a divide-by-ten multiply, plus the output load.
// Zero-distance samples are emitted with present cleared; sample_index and last mark
// position within the frame. No clearing pass follows reset.
module lidar_scan_packet_decoder #(
    parameter int unsigned MAX_SAMPLES = 40
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lspd_stream_if.sink   i_byte,
    lspd_stream_if.source o_res
);
    localparam int unsigned Depth = 2 * MAX_SAMPLES;
    localparam int unsigned AW    = $clog2(Depth);

    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    lspd_pkg::t_frame frame_in;
    lspd_pkg::t_frame frame_head;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [15:0]      wdata;
    logic             re;
    logic [AW-1:0]    raddr;
    logic [15:0]      rdata;

    lspd_front #(.MAX_SAMPLES(MAX_SAMPLES), .AW(AW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_full  (full),
        .o_push  (push),
        .o_frame (frame_in),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata)
    );

    lspd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (frame_in),
        .i_pop   (pop),
        .o_head  (frame_head),
        .o_full  (full),
        .o_empty (empty)
    );

    lspd_ram #(.WIDTH(16), .DEPTH(Depth)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    lspd_back #(.MAX_SAMPLES(MAX_SAMPLES), .AW(AW)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_frame (frame_head),
        .o_pop   (pop),
        .o_re    (re),
        .o_raddr (raddr),
        .i_rdata (rdata),
        .o_res   (o_res)
    );

    // A checked frame is never handed to a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full)) else $error("frame pushed into full queue");

    // The emitter only releases a frame that is queued
    a_pop_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty) else $error("frame released from empty queue");

    // Interpolated angle stays within one turn
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.data.bearing_deg < 9'd360)) else $error("angle out of range");
endmodule
